// File: rtl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg: shared types, constants and helpers for the rectangle corner block
// Holds the CORDIC arctangent table, the stage payload type, the corner sum
// bundle, register and item codes, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

  // CORDIC depth. Only ATAN_ENTRIES table entries exist, so deeper settings clip.
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_CELLS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int STEP_W       = $clog2(ATAN_ENTRIES);

  localparam logic signed [31:0] CORDIC_INV_GAIN = 32'sd652032874;
  localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;

  // Degrees times 64 to Q2.30 radians, scaled by 2^8.
  localparam logic signed [27:0] DEG64_TO_RAD_Q38 = 28'sd74961320;
  // 0.01 in Q0.32, rounded up.
  localparam logic signed [26:0] CENTI_Q32 = 27'sd42949673;

  localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
  localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;

  // Item kinds.
  localparam logic KIND_MOVE   = 1'b0;
  localparam logic KIND_ROTATE = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_X  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_Y  = 2'd3;

  // Data handed from one CORDIC cell to the next.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cordic_vec_t;

  // Rounded rotated offsets of the four corners, before the center is added.
  typedef struct packed {
    logic signed [32:0] tl_x;
    logic signed [32:0] tl_y;
    logic signed [32:0] tr_x;
    logic signed [32:0] tr_y;
    logic signed [32:0] bl_x;
    logic signed [32:0] bl_y;
    logic signed [32:0] br_x;
    logic signed [32:0] br_y;
  } corner_set_t;

  // Truncated Q2.30 values of atan(2^-i).
  function automatic logic signed [31:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic signed [31:0] val;
    case (idx)
      5'd0:    val = 32'sd843314856;
      5'd1:    val = 32'sd497837829;
      5'd2:    val = 32'sd263043836;
      5'd3:    val = 32'sd133525158;
      5'd4:    val = 32'sd67021686;
      5'd5:    val = 32'sd33543515;
      5'd6:    val = 32'sd16775850;
      5'd7:    val = 32'sd8388437;
      5'd8:    val = 32'sd4194282;
      5'd9:    val = 32'sd2097149;
      5'd10:   val = 32'sd1048575;
      5'd11:   val = 32'sd524287;
      5'd12:   val = 32'sd262143;
      5'd13:   val = 32'sd131071;
      5'd14:   val = 32'sd65535;
      5'd15:   val = 32'sd32767;
      5'd16:   val = 32'sd16383;
      5'd17:   val = 32'sd8191;
      5'd18:   val = 32'sd4095;
      5'd19:   val = 32'sd2047;
      5'd20:   val = 32'sd1023;
      5'd21:   val = 32'sd511;
      5'd22:   val = 32'sd255;
      5'd23:   val = 32'sd127;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] res;
    if (v > 34'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rotated_rectangle_corners.sv
// ----------------------------------------------------------------------------
// rotated_rectangle_corners: corners of a moving, rotating rectangle
// Keeps the rectangle center and returns its four corners in Q16.16.
//
// Input channel (in_valid_i/in_ready_o): kind_i = move selects a move tick,
// which adds velocity * 0.01 to the center with saturation and returns the
// unrotated corners; kind_i = rotate returns the corners rotated about the
// center by angle_deg_i (degrees * 64, not accumulated).
// Output channel (out_valid_o/out_ready_i) carries one result per item.
// Config channel (cfg_valid_i/cfg_ready_o) writes width, height and velocity;
// it is always ready. It is to be written only while the block is idle; the
// user is bound to this, and the block itself does not enforce it. One
// transaction is in flight at a time. A move passes through the multiply,
// round and add states, a rotate through the angle multiply and the CORDIC
// cell chain, one step per cell; both then use the shared corner multiplier.
// The next transaction is accepted the cycle after a result is loaded into
// the output register, so a waiting result does not block it, but a second
// result waits inside the block until the receiver takes the first.
// Reset sets width and height to 1.0, velocity and center to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_rectangle_corners (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Configuration
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [rrc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire [31:0]                         cfg_data_i,
  // Input items
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire                                kind_i,
  input  wire signed [15:0]                  angle_deg_i,
  // Results
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic signed [31:0]                 top_left_x_o,
  output logic signed [31:0]                 top_left_y_o,
  output logic signed [31:0]                 top_right_x_o,
  output logic signed [31:0]                 top_right_y_o,
  output logic signed [31:0]                 bottom_left_x_o,
  output logic signed [31:0]                 bottom_left_y_o,
  output logic signed [31:0]                 bottom_right_x_o,
  output logic signed [31:0]                 bottom_right_y_o
);
  import rrc_pkg::*;

  localparam logic [3:0] ST_IDLE        = 4'd0;
  localparam logic [3:0] ST_MOVE_MUL    = 4'd1;
  localparam logic [3:0] ST_MOVE_RND    = 4'd2;
  localparam logic [3:0] ST_MOVE_ADD    = 4'd3;
  localparam logic [3:0] ST_ZMUL        = 4'd4;
  localparam logic [3:0] ST_CORDIC      = 4'd5;
  localparam logic [3:0] ST_CORNER_GO   = 4'd6;
  localparam logic [3:0] ST_CORNER_WAIT = 4'd7;
  localparam logic [3:0] ST_OUT         = 4'd8;

  localparam logic signed [58:0] ROUND_Q32 = 59'sh0_0000_8000_0000;

  logic [3:0]         state_q, state_d;
  logic               in_fire, load_out;

  logic [30:0]        rect_width_q, rect_height_q;
  logic signed [31:0] velocity_x_q, velocity_y_q;
  logic signed [31:0] center_x_q, center_y_q;

  logic signed [16:0] a_wrap, a_half, a_quarter;
  logic               a_flip;
  logic signed [13:0] angle_q;
  logic               flip_q;

  logic signed [58:0] vprod_x_q, vprod_y_q, vprod_x_d, vprod_y_d;
  logic signed [58:0] vrnd_x, vrnd_y;
  logic signed [25:0] delta_x_q, delta_y_q;

  logic signed [41:0] zprod;
  logic signed [31:0] z0_q;
  logic               launch_q;
  cordic_vec_t        head, tail;

  logic signed [31:0] cos_q, sin_q;
  corner_set_t        sums;
  logic               corner_done;

  logic               out_valid_q;
  logic signed [31:0] tl_x_q, tl_y_q, tr_x_q, tr_y_q;
  logic signed [31:0] bl_x_q, bl_y_q, br_x_q, br_y_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_out    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Angle reduction into [-90, 90] degrees, with a sign flip for the far half.
  always_comb begin
    a_wrap = 17'(angle_deg_i);
    if (a_wrap >= FULL_TURN) begin
      a_wrap = a_wrap - FULL_TURN;
    end else if (a_wrap <= -FULL_TURN) begin
      a_wrap = a_wrap + FULL_TURN;
    end
    a_half = a_wrap;
    if (a_wrap >= HALF_TURN) begin
      a_half = a_wrap - FULL_TURN;
    end else if (a_wrap < -HALF_TURN) begin
      a_half = a_wrap + FULL_TURN;
    end
    a_quarter = a_half;
    a_flip    = 1'b0;
    if (a_half > QUARTER_TURN) begin
      a_quarter = a_half - HALF_TURN;
      a_flip    = 1'b1;
    end else if (a_half < -QUARTER_TURN) begin
      a_quarter = a_half + HALF_TURN;
      a_flip    = 1'b1;
    end
  end

  always_comb begin
    vprod_x_d = velocity_x_q * CENTI_Q32;
    vprod_y_d = velocity_y_q * CENTI_Q32;
    vrnd_x    = vprod_x_q + ROUND_Q32;
    vrnd_y    = vprod_y_q + ROUND_Q32;
    zprod     = angle_q * DEG64_TO_RAD_Q38;
  end

  always_comb begin
    head.valid = launch_q;
    head.x     = CORDIC_INV_GAIN;
    head.y     = '0;
    head.z     = z0_q;
  end

  rrc_cordic_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .tail_o (tail)
  );

  rrc_corner_calc u_corner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_CORNER_GO),
    .w_i     (rect_width_q),
    .h_i     (rect_height_q),
    .cos_i   (cos_q),
    .sin_i   (sin_q),
    .sums_o  (sums),
    .done_o  (corner_done)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (kind_i == KIND_ROTATE) ? ST_ZMUL : ST_MOVE_MUL;
        end
      end
      ST_MOVE_MUL:    state_d = ST_MOVE_RND;
      ST_MOVE_RND:    state_d = ST_MOVE_ADD;
      ST_MOVE_ADD:    state_d = ST_CORNER_GO;
      ST_ZMUL:        state_d = ST_CORDIC;
      ST_CORDIC: begin
        if (tail.valid) begin
          state_d = ST_CORNER_GO;
        end
      end
      ST_CORNER_GO:   state_d = ST_CORNER_WAIT;
      ST_CORNER_WAIT: begin
        if (corner_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default:        state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      launch_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      rect_width_q  <= 31'd65536;
      rect_height_q <= 31'd65536;
      velocity_x_q  <= '0;
      velocity_y_q  <= '0;
      center_x_q    <= '0;
      center_y_q    <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= (state_q == ST_ZMUL);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RECT_WIDTH:  rect_width_q  <= cfg_data_i[30:0];
          REG_RECT_HEIGHT: rect_height_q <= cfg_data_i[30:0];
          REG_VELOCITY_X:  velocity_x_q  <= cfg_data_i;
          REG_VELOCITY_Y:  velocity_y_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_MOVE_ADD) begin
        center_x_q <= sat32(34'(center_x_q) + 34'(delta_x_q));
        center_y_q <= sat32(34'(center_y_q) + 34'(delta_y_q));
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      angle_q <= a_quarter[13:0];
      flip_q  <= a_flip;
    end
    if (state_q == ST_MOVE_MUL) begin
      vprod_x_q <= vprod_x_d;
      vprod_y_q <= vprod_y_d;
    end
    if (state_q == ST_MOVE_RND) begin
      delta_x_q <= vrnd_x[57:32];
      delta_y_q <= vrnd_y[57:32];
    end
    if (state_q == ST_MOVE_ADD) begin
      cos_q <= ONE_Q30;
      sin_q <= '0;
    end
    if (state_q == ST_ZMUL) begin
      z0_q <= zprod[39:8];
    end
    if (state_q == ST_CORDIC && tail.valid) begin
      cos_q <= flip_q ? -tail.x : tail.x;
      sin_q <= flip_q ? -tail.y : tail.y;
    end
    if (load_out) begin
      tl_x_q <= sat32(34'(center_x_q) + 34'(sums.tl_x));
      tl_y_q <= sat32(34'(center_y_q) + 34'(sums.tl_y));
      tr_x_q <= sat32(34'(center_x_q) + 34'(sums.tr_x));
      tr_y_q <= sat32(34'(center_y_q) + 34'(sums.tr_y));
      bl_x_q <= sat32(34'(center_x_q) + 34'(sums.bl_x));
      bl_y_q <= sat32(34'(center_y_q) + 34'(sums.bl_y));
      br_x_q <= sat32(34'(center_x_q) + 34'(sums.br_x));
      br_y_q <= sat32(34'(center_y_q) + 34'(sums.br_y));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign top_left_x_o     = tl_x_q;
  assign top_left_y_o     = tl_y_q;
  assign top_right_x_o    = tr_x_q;
  assign top_right_y_o    = tr_y_q;
  assign bottom_left_x_o  = bl_x_q;
  assign bottom_left_y_o  = bl_y_q;
  assign bottom_right_x_o = br_x_q;
  assign bottom_right_y_o = br_y_q;

endmodule

`default_nettype wire

// File: rtl/rrc_cordic_cell.sv
// ----------------------------------------------------------------------------
// rrc_cordic_cell: one rotation step of the CORDIC chain
// Rotates (x, y) by +/- atan(2^-step) toward a zero residual angle and
// registers the result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rrc_cordic_cell (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire [rrc_pkg::STEP_W-1:0]   step_i,
  input  rrc_pkg::cordic_vec_t        prev_i,
  output rrc_pkg::cordic_vec_t        cell_o
);
  import rrc_pkg::*;

  logic               valid_q;
  logic signed [31:0] x_q, y_q, z_q;
  logic signed [31:0] x_d, y_d, z_d;
  logic signed [31:0] xs, ys, angle;

  always_comb begin
    xs    = prev_i.x >>> step_i;
    ys    = prev_i.y >>> step_i;
    angle = atan_q30(step_i);
    if (!prev_i.z[31]) begin
      x_d = prev_i.x - ys;
      y_d = prev_i.y + xs;
      z_d = prev_i.z - angle;
    end else begin
      x_d = prev_i.x + ys;
      y_d = prev_i.y - xs;
      z_d = prev_i.z + angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    cell_o.valid = valid_q;
    cell_o.x     = x_q;
    cell_o.y     = y_q;
    cell_o.z     = z_q;
  end

endmodule

`default_nettype wire

// File: rtl/rrc_cordic_chain.sv
// ----------------------------------------------------------------------------
// rrc_cordic_chain: row of CORDIC cells
// Cell k applies step k; a vector entering the head passes through every cell
// in turn and leaves the tail as (cos, sin) of the starting angle in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module rrc_cordic_chain (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  rrc_pkg::cordic_vec_t head_i,
  output rrc_pkg::cordic_vec_t tail_o
);
  import rrc_pkg::*;

  cordic_vec_t link [NUM_CELLS+1];

  assign link[0] = head_i;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    rrc_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (STEP_W'(k)),
      .prev_i (link[k]),
      .cell_o (link[k+1])
    );
  end

  assign tail_o = link[NUM_CELLS];

endmodule

`default_nettype wire

// File: rtl/rrc_corner_calc.sv
// ----------------------------------------------------------------------------
// rrc_corner_calc: rotated corner offsets
// Forms w*cos, h*sin, w*sin and h*cos on one shared multiplier, then the
// rounded Q16.16 offsets of all four corners. Results hold until next start.
// ----------------------------------------------------------------------------
`default_nettype none

module rrc_corner_calc (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire [30:0]           w_i,
  input  wire [30:0]           h_i,
  input  wire signed [31:0]    cos_i,
  input  wire signed [31:0]    sin_i,
  output rrc_pkg::corner_set_t sums_o,
  output logic                 done_o
);
  import rrc_pkg::*;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_MUL_WC = 3'd1;
  localparam logic [2:0] PH_MUL_HS = 3'd2;
  localparam logic [2:0] PH_MUL_WS = 3'd3;
  localparam logic [2:0] PH_MUL_HC = 3'd4;
  localparam logic [2:0] PH_SUM    = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_4000_0000;

  logic [2:0]         phase_q, phase_d;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic signed [63:0] p_wc_q, p_hs_q, p_ws_q, p_hc_q;
  corner_set_t        sums_q, sums_d;

  function automatic logic signed [32:0] round31(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + ROUND_HALF;
    return t[63:31];
  endfunction

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (phase_q)
      PH_MUL_WC: begin
        op_a = $signed({1'b0, w_i});
        op_b = cos_i;
      end
      PH_MUL_HS: begin
        op_a = $signed({1'b0, h_i});
        op_b = sin_i;
      end
      PH_MUL_WS: begin
        op_a = $signed({1'b0, w_i});
        op_b = sin_i;
      end
      PH_MUL_HC: begin
        op_a = $signed({1'b0, h_i});
        op_b = cos_i;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod = op_a * op_b;
  end

  always_comb begin
    phase_d = phase_q;
    if (start_i) begin
      phase_d = PH_MUL_WC;
    end else begin
      case (phase_q)
        PH_MUL_WC: phase_d = PH_MUL_HS;
        PH_MUL_HS: phase_d = PH_MUL_WS;
        PH_MUL_WS: phase_d = PH_MUL_HC;
        PH_MUL_HC: phase_d = PH_SUM;
        PH_SUM:    phase_d = PH_DONE;
        PH_DONE:   phase_d = PH_DONE;
        default:   phase_d = PH_IDLE;
      endcase
    end
  end

  // Offsets: top (+h), bottom (-h), left (-w), right (+w).
  always_comb begin
    sums_d.tl_x = round31(-p_wc_q - p_hs_q);
    sums_d.tl_y = round31(-p_ws_q + p_hc_q);
    sums_d.tr_x = round31( p_wc_q - p_hs_q);
    sums_d.tr_y = round31( p_ws_q + p_hc_q);
    sums_d.bl_x = round31(-p_wc_q + p_hs_q);
    sums_d.bl_y = round31(-p_ws_q - p_hc_q);
    sums_d.br_x = round31( p_wc_q + p_hs_q);
    sums_d.br_y = round31( p_ws_q - p_hc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_MUL_WC) begin
      p_wc_q <= prod;
    end
    if (phase_q == PH_MUL_HS) begin
      p_hs_q <= prod;
    end
    if (phase_q == PH_MUL_WS) begin
      p_ws_q <= prod;
    end
    if (phase_q == PH_MUL_HC) begin
      p_hc_q <= prod;
    end
    if (phase_q == PH_SUM) begin
      sums_q <= sums_d;
    end
  end

  assign sums_o = sums_q;
  assign done_o = (phase_q == PH_DONE);

endmodule

`default_nettype wire

// File: tb/sv/rotated_rectangle_corners_test.sv
// ----------------------------------------------------------------------------
// rotated_rectangle_corners_test: self-checking bench for the corner block
// Drives move and rotate items with random gaps and output stalls, rewrites the
// size and velocity registers between phases, and compares every result with
// corners predicted from its own copy of the center, a bit-exact CORDIC and the
// Q16.16 rounding and saturation rules.
// ----------------------------------------------------------------------------
module rotated_rectangle_corners_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1250;
  localparam int IDLE_PCT       = 27;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;

  localparam int     TURN_64     = 23040;
  localparam int     HALF_64     = 11520;
  localparam int     QUARTER_64  = 5760;
  localparam longint RAD_SCALE   = 74961320;
  localparam longint GAIN_INV    = 652032874;
  localparam longint UNIT_Q30    = 1073741824;
  localparam longint CENTI_SCALE = 42949673;
  localparam longint ROUND_30    = 64'sd1073741824;
  localparam longint ROUND_31    = 64'sd2147483648;
  localparam int     CORDIC_DEPTH = (rrc_pkg::CORDIC_STEPS < 24) ? rrc_pkg::CORDIC_STEPS : 24;

  localparam longint ATAN_Q30 [24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };

  localparam logic [15:0] EDGE_ANGLES [18] = '{
    16'd0, 16'd1, -16'sd1, 16'd2880, 16'd5760, 16'd5761, -16'sd5760, -16'sd5761,
    16'd11519, 16'd11520, -16'sd11520, 16'd17280, 16'd23039, 16'd23040,
    -16'sd23040, 16'h7FFF, 16'h8000, 16'd12345
  };

  // TL x/y, TR x/y, BL x/y, BR x/y from index 0 upward.
  typedef logic [7:0][31:0] corners_t;

  class corner_scoreboard;
    logic [30:0] side_w, side_h;
    int          vel_x, vel_y, center_x, center_y;
    corners_t    expected_corners[$];
    string       field_names[8];
    int          errors;

    function new();
      side_w   = 31'd65536;
      side_h   = 31'd65536;
      vel_x    = 0;
      vel_y    = 0;
      center_x = 0;
      center_y = 0;
      errors   = 0;
      field_names = '{"top_left_x", "top_left_y", "top_right_x", "top_right_y",
                      "bottom_left_x", "bottom_left_y", "bottom_right_x", "bottom_right_y"};
    endfunction

    function int pending();
      return expected_corners.size();
    endfunction

    function void write_reg(logic [rrc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        rrc_pkg::REG_RECT_WIDTH:  side_w = data[30:0];
        rrc_pkg::REG_RECT_HEIGHT: side_h = data[30:0];
        rrc_pkg::REG_VELOCITY_X:  vel_x = data;
        rrc_pkg::REG_VELOCITY_Y:  vel_y = data;
        default: ;
      endcase
    endfunction

    function int clamp_s32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function void sin_cos(input logic [15:0] angle, output longint c, output longint s);
      int     a;
      bit     flip;
      longint x, y, z, xs, ys;
      a = $signed(angle);
      a = a % TURN_64;
      if (a >= HALF_64) a -= TURN_64;
      if (a < -HALF_64) a += TURN_64;
      // Fold into the right half plane, where CORDIC converges, and negate after.
      flip = 1'b0;
      if (a > QUARTER_64) begin
        a -= HALF_64;
        flip = 1'b1;
      end else if (a < -QUARTER_64) begin
        a += HALF_64;
        flip = 1'b1;
      end
      z = (longint'(a) * RAD_SCALE) >>> 8;
      x = GAIN_INV;
      y = 0;
      for (int i = 0; i < CORDIC_DEPTH; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= ATAN_Q30[i];
        end else begin
          x += ys;
          y -= xs;
          z += ATAN_Q30[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void place_corner(input longint dx, input longint dy, input longint c,
                               input longint s, output logic [31:0] px,
                               output logic [31:0] py);
      px = clamp_s32(center_x + ((dx * c - dy * s + ROUND_30) >>> 31));
      py = clamp_s32(center_y + ((dx * s + dy * c + ROUND_30) >>> 31));
    endfunction

    function void note_item(logic kind, logic [15:0] angle);
      longint   c, s, w, h, dx, dy;
      corners_t want;
      if (kind == rrc_pkg::KIND_MOVE) begin
        dx = (longint'(vel_x) * CENTI_SCALE + ROUND_31) >>> 32;
        dy = (longint'(vel_y) * CENTI_SCALE + ROUND_31) >>> 32;
        center_x = clamp_s32(center_x + dx);
        center_y = clamp_s32(center_y + dy);
        c = UNIT_Q30;
        s = 0;
      end else begin
        sin_cos(angle, c, s);
      end
      w = side_w;
      h = side_h;
      place_corner(-w, h, c, s, want[0], want[1]);
      place_corner(w, h, c, s, want[2], want[3]);
      place_corner(-w, -h, c, s, want[4], want[5]);
      place_corner(w, -h, c, s, want[6], want[7]);
      expected_corners.push_back(want);
    endfunction

    function void check_corners(corners_t got);
      corners_t want;
      if (expected_corners.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got top_left_x %0d",
                 $time, $signed(got[0]));
        return;
      end
      want = expected_corners.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (want[i] !== got[i]) begin
          errors++;
          $display("%0t: %s expected %0d, actual %0d", $time, field_names[i],
                   $signed(want[i]), $signed(got[i]));
        end
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [rrc_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [31:0]                     cfg_data_i  = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic                            kind_i      = 1'b0;
  logic signed [15:0]              angle_deg_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic signed [31:0]              top_left_x_o, top_left_y_o, top_right_x_o, top_right_y_o;
  logic signed [31:0]              bottom_left_x_o, bottom_left_y_o;
  logic signed [31:0]              bottom_right_x_o, bottom_right_y_o;

  corner_scoreboard sb;
  bit               steady = 1'b0;
  int               quiet_cycles = 0;

  rotated_rectangle_corners u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .angle_deg_i      (angle_deg_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .top_left_x_o     (top_left_x_o),
    .top_left_y_o     (top_left_y_o),
    .top_right_x_o    (top_right_x_o),
    .top_right_y_o    (top_right_y_o),
    .bottom_left_x_o  (bottom_left_x_o),
    .bottom_left_y_o  (bottom_left_y_o),
    .bottom_right_x_o (bottom_right_x_o),
    .bottom_right_y_o (bottom_right_y_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_corners({bottom_right_y_o, bottom_right_x_o, bottom_left_y_o, bottom_left_x_o,
                        top_right_y_o, top_right_x_o, top_left_y_o, top_left_x_o});
    end
  end

  // Ends the run if no transaction of any kind completes for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_angle();
    int a;
    case ($urandom_range(9))
      0, 1, 2: a = int'($urandom_range(2 * TURN_64)) - TURN_64;
      3, 4:    a = QUARTER_64 * (int'($urandom_range(8)) - 4) + int'($urandom_range(2)) - 1;
      default: a = int'($urandom_range(65535));
    endcase
    return a[15:0];
  endfunction

  function automatic logic [31:0] pick_side();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1 << 18, 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return int'($urandom_range(1 << 22)) - (1 << 21);
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic write_reg(logic [rrc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(bit every_reg);
    if (every_reg || $urandom_range(99) < 60) write_reg(rrc_pkg::REG_RECT_WIDTH, pick_side());
    if (every_reg || $urandom_range(99) < 60) write_reg(rrc_pkg::REG_RECT_HEIGHT, pick_side());
    if (every_reg || $urandom_range(99) < 60) write_reg(rrc_pkg::REG_VELOCITY_X, pick_velocity());
    if (every_reg || $urandom_range(99) < 60) write_reg(rrc_pkg::REG_VELOCITY_Y, pick_velocity());
    cfg_valid_i <= 1'b0;
  endtask

  // Valid stays high after acceptance, so back-to-back items keep it high with no gap.
  task automatic send_item(logic kind, logic [15:0] angle);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    angle_deg_i <= angle;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(kind, angle);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent;
    int phase;
    int count;
    int move_pct;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: moves with a stray angle, then angles around every quadrant
    // boundary, past a full turn and at the field limits.
    send_item(rrc_pkg::KIND_MOVE, 16'h7FFF);
    send_item(rrc_pkg::KIND_MOVE, 16'h8000);
    for (int i = 0; i < 18; i++) send_item(rrc_pkg::KIND_ROTATE, EDGE_ANGLES[i]);
    settle();

    // Zero width, largest height and the extreme velocities.
    write_reg(rrc_pkg::REG_RECT_WIDTH, 32'h0000_0000);
    write_reg(rrc_pkg::REG_RECT_HEIGHT, 32'hFFFF_FFFF);
    write_reg(rrc_pkg::REG_VELOCITY_X, 32'h7FFF_FFFF);
    write_reg(rrc_pkg::REG_VELOCITY_Y, 32'h8000_0000);
    cfg_valid_i <= 1'b0;
    send_item(rrc_pkg::KIND_MOVE, 16'h0000);
    send_item(rrc_pkg::KIND_ROTATE, 16'd2880);
    send_item(rrc_pkg::KIND_MOVE, 16'hFFFF);
    send_item(rrc_pkg::KIND_ROTATE, -16'sd8640);

    // The first phase keeps the extreme velocities and mostly moves, which drives
    // the center into saturation on both axes.
    sent  = 0;
    phase = 0;
    while (sent < ITEM_TARGET) begin
      count    = (phase == 0) ? 160 : $urandom_range(200, 60);
      move_pct = (phase == 0) ? 95 : $urandom_range(80, 20);
      steady   <= (phase == 2);
      for (int n = 0; n < count; n++) begin
        send_item(($urandom_range(99) < move_pct) ? rrc_pkg::KIND_MOVE : rrc_pkg::KIND_ROTATE,
                  pick_angle());
      end
      sent += count;
      settle();
      steady <= 1'b0;
      if (sent < ITEM_TARGET) configure(phase == 1);
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
